// ===== rtl/pstp_pkg.sv =====
`timescale 1ns / 1ps

package pstp_pkg;

  // What the parser expects next
  localparam logic [2:0] EXP_CMD    = 3'd0;
  localparam logic [2:0] EXP_NONE   = 3'd1;
  localparam logic [2:0] EXP_SHORT  = 3'd2;
  localparam logic [2:0] EXP_IEEE   = 3'd3;
  localparam logic [2:0] EXP_CHAR   = 3'd4;
  localparam logic [2:0] EXP_STRING = 3'd5;

  // Token kinds
  localparam logic [2:0] TOK_CMD     = 3'd0;
  localparam logic [2:0] TOK_BAD     = 3'd1;
  localparam logic [2:0] TOK_SHORT   = 3'd2;
  localparam logic [2:0] TOK_DOUBLE  = 3'd3;
  localparam logic [2:0] TOK_CHAR    = 3'd4;
  localparam logic [2:0] TOK_STRCHAR = 3'd5;
  localparam logic [2:0] TOK_STREND  = 3'd6;

  localparam logic [63:0] SHORT_MAX_POS = 64'h0000_0000_0000_7FFF;
  localparam logic [7:0]  LINE_END      = 8'h0A;
  localparam logic [2:0]  LAST_IEEE_POS = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  command_code;
    logic [63:0] arg_value;
    logic [2:0]  arg_index;
    logic        last_of_command;
  } token_t;

  typedef struct packed {
    logic [2:0] kind;   // EXP_CMD means no such command
    logic [2:0] count;
  } cmd_info_t;

  function automatic cmd_info_t cmd_lookup(input logic [7:0] b);
    cmd_info_t r;
    r.kind  = EXP_CMD;
    r.count = 3'd0;
    unique case (b)
      "C": begin r.kind = EXP_CHAR;   r.count = 3'd3; end
      "F": begin r.kind = EXP_NONE;   r.count = 3'd0; end
      "L": begin r.kind = EXP_SHORT;  r.count = 3'd6; end
      "M": begin r.kind = EXP_SHORT;  r.count = 3'd3; end
      "N": begin r.kind = EXP_SHORT;  r.count = 3'd3; end
      "O": begin r.kind = EXP_IEEE;   r.count = 3'd3; end
      "P": begin r.kind = EXP_SHORT;  r.count = 3'd3; end
      "Q": begin r.kind = EXP_IEEE;   r.count = 3'd3; end
      "S": begin r.kind = EXP_SHORT;  r.count = 3'd6; end
      "V": begin r.kind = EXP_IEEE;   r.count = 3'd6; end
      "W": begin r.kind = EXP_IEEE;   r.count = 3'd6; end
      "X": begin r.kind = EXP_IEEE;   r.count = 3'd3; end
      "a": begin r.kind = EXP_SHORT;  r.count = 3'd6; end
      "c": begin r.kind = EXP_SHORT;  r.count = 3'd3; end
      "e": begin r.kind = EXP_NONE;   r.count = 3'd0; end
      "f": begin r.kind = EXP_STRING; r.count = 3'd1; end
      "i": begin r.kind = EXP_IEEE;   r.count = 3'd3; end
      "l": begin r.kind = EXP_SHORT;  r.count = 3'd4; end
      "m": begin r.kind = EXP_SHORT;  r.count = 3'd2; end
      "n": begin r.kind = EXP_SHORT;  r.count = 3'd2; end
      "o": begin r.kind = EXP_IEEE;   r.count = 3'd2; end
      "p": begin r.kind = EXP_SHORT;  r.count = 3'd2; end
      "q": begin r.kind = EXP_IEEE;   r.count = 3'd2; end
      "r": begin r.kind = EXP_IEEE;   r.count = 3'd6; end
      "s": begin r.kind = EXP_SHORT;  r.count = 3'd4; end
      "t": begin r.kind = EXP_STRING; r.count = 3'd1; end
      "v": begin r.kind = EXP_IEEE;   r.count = 3'd4; end
      "w": begin r.kind = EXP_IEEE;   r.count = 3'd4; end
      "x": begin r.kind = EXP_IEEE;   r.count = 3'd2; end
      default: begin r.kind = EXP_CMD; r.count = 3'd0; end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/pstp_in_stage.sv =====
`timescale 1ns / 1ps

module pstp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  output logic       in_stall,
  input  logic       take,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);
  import pstp_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (!valid_r || take) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_data_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

// ===== rtl/pstp_token_unit.sv =====
`timescale 1ns / 1ps

module pstp_token_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      s1_byte,
  output logic            tok_valid,
  output pstp_pkg::token_t tok
);
  import pstp_pkg::*;

  logic [2:0]  expect_r, expect_nxt;
  logic [2:0]  args_left_r, args_left_nxt;
  logic [2:0]  byte_pos_r, byte_pos_nxt;
  logic [63:0] asm_r, asm_nxt;
  logic [7:0]  cur_cmd_r, cur_cmd_nxt;
  logic [2:0]  arg_num_r, arg_num_nxt;

  cmd_info_t   info;
  logic [63:0] short_val;
  logic [63:0] ieee_val;
  logic        last_arg;
  logic        finish;
  logic [2:0]  fin_kind;
  logic [63:0] fin_val;

  assign info      = cmd_lookup(s1_byte);
  assign last_arg  = (args_left_r <= 3'd1);
  assign ieee_val  = {asm_r[55:0], s1_byte};

  always_comb begin
    short_val = asm_r | {48'd0, s1_byte, 8'd0};
    if (short_val > SHORT_MAX_POS) begin
      short_val = short_val | ~SHORT_MAX_POS;
    end
  end

  always_comb begin
    expect_nxt    = expect_r;
    args_left_nxt = args_left_r;
    byte_pos_nxt  = byte_pos_r;
    asm_nxt       = asm_r;
    cur_cmd_nxt   = cur_cmd_r;
    arg_num_nxt   = arg_num_r;
    tok_valid     = 1'b0;
    tok           = '0;
    finish        = 1'b0;
    fin_kind      = TOK_CHAR;
    fin_val       = {56'd0, s1_byte};

    unique case (expect_r)
      EXP_SHORT: begin
        if (byte_pos_r == 3'd0) begin
          asm_nxt      = {56'd0, s1_byte};
          byte_pos_nxt = 3'd1;
        end else begin
          finish   = 1'b1;
          fin_kind = TOK_SHORT;
          fin_val  = short_val;
        end
      end
      EXP_IEEE: begin
        asm_nxt = ieee_val;
        if (byte_pos_r < LAST_IEEE_POS) begin
          byte_pos_nxt = byte_pos_r + 3'd1;
        end else begin
          finish   = 1'b1;
          fin_kind = TOK_DOUBLE;
          fin_val  = ieee_val;
        end
      end
      EXP_CHAR: begin
        finish   = 1'b1;
        fin_kind = TOK_CHAR;
      end
      EXP_STRING: begin
        tok_valid        = 1'b1;
        tok.command_code = cur_cmd_r;
        tok.arg_value    = {56'd0, s1_byte};
        tok.arg_index    = 3'd0;
        if (s1_byte == LINE_END) begin
          tok.kind            = TOK_STREND;
          tok.last_of_command = 1'b1;
          args_left_nxt       = 3'd0;
          arg_num_nxt         = 3'd0;
          byte_pos_nxt        = 3'd0;
          expect_nxt          = EXP_CMD;
        end else begin
          tok.kind            = TOK_STRCHAR;
          tok.last_of_command = 1'b0;
        end
      end
      default: begin
        // command byte; stray codes fall here too
        tok_valid        = 1'b1;
        tok.command_code = s1_byte;
        tok.arg_value    = '0;
        tok.arg_index    = 3'd0;
        expect_nxt       = EXP_CMD;
        if (info.kind == EXP_CMD) begin
          tok.kind            = TOK_BAD;
          tok.last_of_command = 1'b1;
        end else begin
          tok.kind     = TOK_CMD;
          cur_cmd_nxt  = s1_byte;
          byte_pos_nxt = 3'd0;
          asm_nxt      = '0;
          arg_num_nxt  = 3'd0;
          if (info.kind == EXP_NONE || info.count == 3'd0) begin
            args_left_nxt       = 3'd0;
            tok.last_of_command = 1'b1;
          end else begin
            args_left_nxt       = info.count;
            expect_nxt          = info.kind;
            tok.last_of_command = 1'b0;
          end
        end
      end
    endcase

    if (finish) begin
      tok_valid           = 1'b1;
      tok.kind            = fin_kind;
      tok.command_code    = cur_cmd_r;
      tok.arg_value       = fin_val;
      tok.arg_index       = arg_num_r;
      tok.last_of_command = last_arg;
      byte_pos_nxt        = 3'd0;
      asm_nxt             = '0;
      if (last_arg) begin
        args_left_nxt = 3'd0;
        arg_num_nxt   = 3'd0;
        expect_nxt    = EXP_CMD;
      end else begin
        args_left_nxt = args_left_r - 3'd1;
        arg_num_nxt   = arg_num_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r    <= EXP_CMD;
      args_left_r <= 3'd0;
      byte_pos_r  <= 3'd0;
      asm_r       <= '0;
      cur_cmd_r   <= 8'd0;
      arg_num_r   <= 3'd0;
    end else if (take) begin
      expect_r    <= expect_nxt;
      args_left_r <= args_left_nxt;
      byte_pos_r  <= byte_pos_nxt;
      asm_r       <= asm_nxt;
      cur_cmd_r   <= cur_cmd_nxt;
      arg_num_r   <= arg_num_nxt;
    end
  end

  // Between commands no argument bytes are pending
  a_cmd_no_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (expect_r == EXP_CMD) |-> (byte_pos_r == 3'd0))
    else $error("partial argument bytes while expecting a command");

  // Inside a command at least one argument remains
  a_args_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (expect_r != EXP_CMD) |-> (args_left_r != 3'd0))
    else $error("collecting arguments with none left");

  // Only multi-byte arguments track a byte position
  a_pos_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_pos_r != 3'd0) |-> (expect_r == EXP_SHORT || expect_r == EXP_IEEE))
    else $error("byte position set outside a multi-byte argument");

endmodule

// ===== rtl/pstp_out_stage.sv =====
`timescale 1ns / 1ps

module pstp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic             tok_valid,
  input  pstp_pkg::token_t tok,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_token_kind,
  output logic [7:0]       out_command_code,
  output logic [63:0]      out_arg_value,
  output logic [2:0]       out_arg_index,
  output logic             out_last_of_command
);
  import pstp_pkg::*;

  logic   valid_r, valid_nxt;
  token_t tok_r;

  assign ready = !(valid_r && out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (ready) begin
      valid_nxt = take && tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && take && tok_valid) begin
      tok_r <= tok;
    end
  end

  assign out_valid           = valid_r;
  assign out_token_kind      = tok_r.kind;
  assign out_command_code    = tok_r.command_code;
  assign out_arg_value       = tok_r.arg_value;
  assign out_arg_index       = tok_r.arg_index;
  assign out_last_of_command = tok_r.last_of_command;

endmodule

// ===== rtl/plot_stream_token_parser_core.sv =====
`timescale 1ns / 1ps

// Parses a binary plot command stream, one byte per transaction, into tokens:
// a command or bad-command token per command byte, one token per finished
// argument (16-bit little-endian shorts sign-extended to 64 bits, 64-bit
// big-endian doubles as raw bits, chars), and one token per string byte up to
// the linefeed. Bytes that only partly fill an argument give no token. The
// block takes a byte every cycle while out_stall does not hold it back; a
// byte is held in the input register, and its token is set by the result
// register behind the combinational table lookup and assembly step. in_stall
// follows out_stall combinationally when both registers are full.
module plot_stream_token_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_data_byte,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic [7:0]  out_command_code,
  output logic [63:0] out_arg_value,
  output logic [2:0]  out_arg_index,
  output logic        out_last_of_command
);
  import pstp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_ready;
  logic       take;
  logic       tok_valid;
  token_t     tok;

  assign take = s1_valid && out_ready;

  pstp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .take         (take),
    .s1_valid     (s1_valid),
    .s1_byte      (s1_byte)
  );

  pstp_token_unit u_tok (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .s1_byte   (s1_byte),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  pstp_out_stage u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .take                (take),
    .tok_valid           (tok_valid),
    .tok                 (tok),
    .ready               (out_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_command_code    (out_command_code),
    .out_arg_value       (out_arg_value),
    .out_arg_index       (out_arg_index),
    .out_last_of_command (out_last_of_command)
  );

endmodule
